// ===== rtl/reca_pkg.sv =====
// Shared constants and types of the ring cellular automaton.
package reca_pkg;

  // Number of cells in the ring by default, and the width of the row fields.
  localparam int CELLS_DEFAULT = 8;
  localparam int CHANNELS      = 8;

  // Live count field.
  localparam int LIVE_W   = 4;
  localparam int LIVE_MAX = 15;

  // Two-bit signed codes for direction and level sign.
  localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
  localparam logic signed [1:0] SIGN_POS  = 2'sb01;
  localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

  // Control common to every cell of the ring for one beat.
  typedef struct packed {
    logic       step;
    logic [7:0] rule;
  } cell_ctrl_t;

endpackage

// ===== rtl/reca_if.sv =====
// Handshake interfaces for the tick and result channels.
interface reca_tick_if import reca_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    step_pulse;
  logic [7:0]              rule;
  logic                    scan_plugged;
  logic signed [1:0]       scan_level_sign;
  logic                    scan_flip_pulse;
  logic [CHANNELS-1:0]     toggle_next;
  logic [CHANNELS-1:0]     toggle_shown;

  modport source (
    output valid, step_pulse, rule, scan_plugged, scan_level_sign,
           scan_flip_pulse, toggle_next, toggle_shown,
    input  ready
  );
  modport sink (
    input  valid, step_pulse, rule, scan_plugged, scan_level_sign,
           scan_flip_pulse, toggle_next, toggle_shown,
    output ready
  );
endinterface

interface reca_result_if import reca_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHANNELS-1:0] shown_cells;
  logic [CHANNELS-1:0] next_cells;
  logic [LIVE_W-1:0]   live_count;
  logic [CHANNELS-1:0] row_number;
  logic                scan_backward;

  modport source (
    output valid, shown_cells, next_cells, live_count, row_number, scan_backward,
    input  ready
  );
  modport sink (
    input  valid, shown_cells, next_cells, live_count, row_number, scan_backward,
    output ready
  );
endinterface

// ===== rtl/reca_cell.sv =====
// One cell of the ring: holds its next and shown bits and applies the rule.
module reca_cell import reca_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  cell_ctrl_t ctrl,
  input  logic       left,
  input  logic       right,
  input  logic       tog_next,
  input  logic       tog_shown,
  output logic       next_cell,
  output logic       next_cell_next,
  output logic       shown_cell_next
);

  logic       shown_cell;
  logic [2:0] nbhd;
  logic       gen;

  // The neighbourhood of left, self and right picks one bit of the rule.
  assign nbhd = {left, next_cell, right};
  assign gen  = ctrl.rule[nbhd];

  // A step moves the next bit into the shown bit; toggles act afterwards.
  assign shown_cell_next = (ctrl.step ? next_cell : shown_cell) ^ tog_shown;
  assign next_cell_next  = (ctrl.step ? gen : next_cell) ^ tog_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_cell  <= 1'b0;
      shown_cell <= 1'b0;
    end else if (en) begin
      next_cell  <= next_cell_next;
      shown_cell <= shown_cell_next;
    end
  end

endmodule

// ===== rtl/reca_dir.sv =====
// Scan direction tracker: follows the level sign and flip pulses.
module reca_dir import reca_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              plugged,
  input  logic signed [1:0] level_raw,
  input  logic              flip,
  output logic              backward_next
);

  logic signed [1:0] direction;
  logic signed [1:0] direction_next;
  logic signed [1:0] last_level;
  logic signed [1:0] last_level_next;
  logic signed [1:0] level;
  logic signed [1:0] chosen;
  logic signed [1:0] settled;

  // Both negative patterns count as minus one.
  always_comb begin
    unique case (level_raw)
      SIGN_ZERO: level = SIGN_ZERO;
      SIGN_POS:  level = SIGN_POS;
      default:   level = SIGN_NEG;
    endcase
  end

  // A change of the chosen sign overrides the direction; a flip negates it.
  always_comb begin
    chosen = plugged ? level : direction;
    if (chosen != last_level) begin
      settled         = chosen;
      last_level_next = chosen;
    end else begin
      settled         = direction;
      last_level_next = last_level;
    end
    direction_next = flip ? -settled : settled;
  end

  assign backward_next = direction_next[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= SIGN_POS;
      last_level <= SIGN_ZERO;
    end else if (en) begin
      direction  <= direction_next;
      last_level <= last_level_next;
    end
  end

endmodule

// ===== rtl/ring_elementary_cellular_automaton_core.sv =====
// Top level of the ring elementary cellular automaton.
// The block takes one tick beat per clock while tick ready is high and returns exactly
// one result beat for each, in order. Every tick advances a ring of CELLS cells; each
// cell updates its own state from its two neighbours in the same cycle, and the result
// is registered into the output stage on acceptance. A two-entry output stage
// (output register plus skid register) lets ticks keep flowing while a result waits;
// tick ready drops only when both entries hold results that have not been taken.
// Cells beyond the eighth receive no toggles and are cut from the row fields, while the
// live count covers the whole ring and saturates at fifteen. No clearing pass follows
// reset; the block is ready on the first cycle after reset is released.
module ring_elementary_cellular_automaton_core import reca_pkg::*; #(
  parameter int CELLS = CELLS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  reca_tick_if.sink     tick,
  reca_result_if.source result
);

  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int EXT_W = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;
  localparam int PAD_W = (CELLS > CHANNELS) ? CELLS : CHANNELS;

  typedef struct packed {
    logic [CHANNELS-1:0] shown_cells;
    logic [CHANNELS-1:0] next_cells;
    logic [LIVE_W-1:0]   live_count;
    logic [CHANNELS-1:0] row_number;
    logic                scan_backward;
  } result_t;

  logic             accept;
  logic             fire;
  cell_ctrl_t       ctrl;
  logic [CELLS-1:0] next_row;
  logic [CELLS-1:0] next_row_next;
  logic [CELLS-1:0] shown_row_next;
  logic [CELLS-1:0] shown_rev;
  logic [CELLS-1:0] number;
  logic [EXT_W-1:0] cnt;
  logic [PAD_W-1:0] shown_pad;
  logic [PAD_W-1:0] next_pad;
  logic [PAD_W-1:0] number_pad;
  logic             backward_next;
  result_t          res_new;
  result_t          out_data;
  result_t          skid_data;
  logic             out_valid;
  logic             skid_valid;

  // Handshake: accept while the skid register is free.
  assign tick.ready = !skid_valid;
  assign accept     = tick.valid && tick.ready;
  assign fire       = out_valid && result.ready;

  assign ctrl.step = tick.step_pulse;
  assign ctrl.rule = tick.rule;

  // The ring of cells, each wired to its left and right neighbour.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    localparam int LEFT  = (i + CELLS - 1) % CELLS;
    localparam int RIGHT = (i + 1) % CELLS;
    logic tog_n;
    logic tog_s;

    if (i < CHANNELS) begin : g_tog
      assign tog_n = tick.toggle_next[i];
      assign tog_s = tick.toggle_shown[i];
    end else begin : g_no_tog
      assign tog_n = 1'b0;
      assign tog_s = 1'b0;
    end

    reca_cell u_cell (
      .clk             (clk),
      .rst             (rst),
      .en              (accept),
      .ctrl            (ctrl),
      .left            (next_row[LEFT]),
      .right           (next_row[RIGHT]),
      .tog_next        (tog_n),
      .tog_shown       (tog_s),
      .next_cell       (next_row[i]),
      .next_cell_next  (next_row_next[i]),
      .shown_cell_next (shown_row_next[i])
    );

    assign shown_rev[i] = shown_row_next[CELLS-1-i];
  end

  reca_dir u_dir (
    .clk           (clk),
    .rst           (rst),
    .en            (accept),
    .plugged       (tick.scan_plugged),
    .level_raw     (tick.scan_level_sign),
    .flip          (tick.scan_flip_pulse),
    .backward_next (backward_next)
  );

  // Result of the tick being accepted, taken from the updated rows.
  assign cnt        = EXT_W'($countones(shown_row_next));
  assign number     = backward_next ? shown_rev : shown_row_next;
  assign shown_pad  = PAD_W'(shown_row_next);
  assign next_pad   = PAD_W'(next_row_next);
  assign number_pad = PAD_W'(number);

  always_comb begin
    res_new.shown_cells   = shown_pad[CHANNELS-1:0];
    res_new.next_cells    = next_pad[CHANNELS-1:0];
    res_new.row_number    = number_pad[CHANNELS-1:0];
    res_new.scan_backward = backward_next;
    if (cnt > EXT_W'(LIVE_MAX)) begin
      res_new.live_count = LIVE_W'(LIVE_MAX);
    end else begin
      res_new.live_count = LIVE_W'(cnt);
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (fire) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_data <= res_new;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid) begin
        out_data  <= res_new;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res_new;
        skid_valid <= 1'b1;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.shown_cells   = out_data.shown_cells;
  assign result.next_cells    = out_data.next_cells;
  assign result.live_count    = out_data.live_count;
  assign result.row_number    = out_data.row_number;
  assign result.scan_backward = out_data.scan_backward;

endmodule

// ===== rtl/reca_checker.sv =====
// Port-level checks on the ring cellular automaton, bound to the top level.
module reca_checker import reca_pkg::*; #(
  parameter int CELLS = CELLS_DEFAULT
) (
  input logic                clk,
  input logic                rst,
  input logic                tick_ready,
  input logic                result_valid,
  input logic                result_ready,
  input logic [CHANNELS-1:0] shown_cells,
  input logic [LIVE_W-1:0]   live_count,
  input logic [CHANNELS-1:0] row_number,
  input logic                scan_backward
);

  // A stalled result beat holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(shown_cells)
      && $stable(live_count) && $stable(row_number)
      && $stable(scan_backward))
    else $error("result beat changed while stalled");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Tick ready drops only while a result is waiting.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !tick_ready |-> result_valid)
    else $error("tick stalled with no result pending");

  // When the whole ring fits the field, the live count matches the shown row.
  a_live_count: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (CELLS > CHANNELS) || (int'(live_count) == $countones(shown_cells)))
    else $error("live count does not match shown row");

  // Scanning forward, the row number is the shown row itself.
  a_row_forward: assert property (@(posedge clk) disable iff (rst)
    result_valid && !scan_backward |-> row_number == shown_cells)
    else $error("forward row number differs from shown row");

endmodule

bind ring_elementary_cellular_automaton_core reca_checker #(.CELLS(CELLS)) u_reca_checker (
  .clk           (clk),
  .rst           (rst),
  .tick_ready    (tick.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .shown_cells   (result.shown_cells),
  .live_count    (result.live_count),
  .row_number    (result.row_number),
  .scan_backward (result.scan_backward)
);
